// ===== hdl/gzip_header_stripper_top_macros.svh =====
// ----------------------------------------------------------------------------
// gzip header stripper assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef GZIP_HEADER_STRIPPER_TOP_MACROS_SVH
`define GZIP_HEADER_STRIPPER_TOP_MACROS_SVH

// property holds at every edge out of reset
`define GZHS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define GZHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/gzhs_pkg.sv =====
// ----------------------------------------------------------------------------
// gzhs_pkg
// word types and constants of the gzip header stripper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gzhs_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_word_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] out_byte;
    logic       status;
    logic       is_last;
  } out_word_t;

  localparam logic [7:0] MAGIC0      = 8'h1F;
  localparam logic [7:0] MAGIC1      = 8'h8B;
  localparam logic [7:0] METHOD_DEFL = 8'h08;

  localparam logic [4:0] FLG_FHCRC    = 5'h02;
  localparam logic [4:0] FLG_FEXTRA   = 5'h04;
  localparam logic [4:0] FLG_FNAME    = 5'h08;
  localparam logic [4:0] FLG_FCOMMENT = 5'h10;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam int unsigned FIXED_HDR_LEN = 10;
  localparam int unsigned TRAILER_LEN   = 8;

endpackage

// ===== hdl/gzip_header_stripper_top.sv =====
// ----------------------------------------------------------------------------
// gzip_header_stripper_top
// strips the gzip member header and passes the deflate payload on
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle while in_ready is high and updates the
// header parse state in a single registered step; results appear at the
// output in the cycle after the byte is taken. The output register holds up
// to two words: the byte that ends a stream with a full trailer line produces
// a payload word and the status word, and in_ready then stays low until the
// payload word is taken. Every other byte yields at most one word. The last
// eight bytes of a stream are held in an eight-byte shift line and never
// passed on. A bad magic or method byte yields an error status at once and
// the rest of the stream is dropped with no second status.
`timescale 1ns / 1ps
`include "gzip_header_stripper_top_macros.svh"

module gzip_header_stripper_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gzhs_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gzhs_pkg::out_word_t out_data
);

  typedef enum logic [2:0] {
    PH_FIXED,
    PH_XLEN,
    PH_XDATA,
    PH_NAME,
    PH_COMMENT,
    PH_HCRC,
    PH_PAYLOAD,
    PH_DISCARD
  } phase_t;

  localparam int unsigned TRL = gzhs_pkg::TRAILER_LEN;

  phase_t     phase_r, phase_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic [4:0] flags_r, flags_nxt;
  logic [15:0] xrem_r, xrem_nxt;
  logic [7:0] xlow_r, xlow_nxt;
  logic [3:0] fill_r, fill_nxt;
  logic [TRL-1:0][7:0] dly_r;
  logic       dly_shift;

  gzhs_pkg::out_word_t res0_r, res1_r, r0, r1;
  logic [1:0] cnt_r, n_res;

  logic in_acc, out_acc;
  logic [7:0] b;
  logic eos, bad, emit;
  logic dly_full;

  // first optional field at or after 'from' whose flag is set
  function automatic phase_t enter_from(phase_t from, logic [4:0] fl);
    phase_t p;
    p = PH_PAYLOAD;
    priority if (from <= PH_XLEN && (fl & gzhs_pkg::FLG_FEXTRA) != '0)
      p = PH_XLEN;
    else if (from <= PH_NAME && (fl & gzhs_pkg::FLG_FNAME) != '0)
      p = PH_NAME;
    else if (from <= PH_COMMENT && (fl & gzhs_pkg::FLG_FCOMMENT) != '0)
      p = PH_COMMENT;
    else if (from <= PH_HCRC && (fl & gzhs_pkg::FLG_FHCRC) != '0)
      p = PH_HCRC;
    return p;
  endfunction

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = res0_r;
  assign out_acc   = out_valid && out_ready;
  // room when empty, or once the last buffered word leaves this cycle
  assign in_ready  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);
  assign in_acc    = in_valid && in_ready;

  assign b        = in_data.in_byte;
  assign eos      = in_data.end_of_stream;
  assign dly_full = (fill_r == 4'(TRL));

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    flags_nxt = flags_r;
    xrem_nxt  = xrem_r;
    xlow_nxt  = xlow_r;
    fill_nxt  = fill_r;
    dly_shift = 1'b0;
    bad       = 1'b0;
    emit      = 1'b0;
    r0        = '0;
    r1        = '0;
    n_res     = 2'd0;

    unique case (phase_r)
      PH_FIXED: begin
        bad = (pos_r == 4'd0 && b != gzhs_pkg::MAGIC0) ||
              (pos_r == 4'd1 && b != gzhs_pkg::MAGIC1) ||
              (pos_r == 4'd2 && b != gzhs_pkg::METHOD_DEFL);
        if (bad) begin
          phase_nxt = PH_DISCARD;
        end else begin
          if (pos_r == 4'd3) flags_nxt = b[4:0];
          if (pos_r >= 4'(gzhs_pkg::FIXED_HDR_LEN - 1)) begin
            pos_nxt   = '0;
            phase_nxt = enter_from(PH_XLEN, flags_r);
          end else begin
            pos_nxt = pos_r + 4'd1;
          end
        end
      end
      PH_XLEN: begin
        if (pos_r == 4'd0) begin
          xlow_nxt = b;
          pos_nxt  = 4'd1;
        end else if ({b, xlow_r} == 16'd0) begin
          pos_nxt   = '0;
          phase_nxt = enter_from(PH_NAME, flags_r);
        end else begin
          xrem_nxt  = {b, xlow_r};
          phase_nxt = PH_XDATA;
        end
      end
      PH_XDATA: begin
        if (xrem_r != '0) xrem_nxt = xrem_r - 16'd1;
        if (xrem_r <= 16'd1) begin
          pos_nxt   = '0;
          phase_nxt = enter_from(PH_NAME, flags_r);
        end
      end
      PH_NAME: begin
        if (b == 8'd0) begin
          pos_nxt   = '0;
          phase_nxt = enter_from(PH_COMMENT, flags_r);
        end
      end
      PH_COMMENT: begin
        if (b == 8'd0) begin
          pos_nxt   = '0;
          phase_nxt = enter_from(PH_HCRC, flags_r);
        end
      end
      PH_HCRC: begin
        if (pos_r == 4'd0) begin
          pos_nxt = 4'd1;
        end else begin
          pos_nxt   = '0;
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        dly_shift = 1'b1;
        emit      = dly_full;
        if (!dly_full) fill_nxt = fill_r + 4'd1;
      end
      PH_DISCARD: begin
      end
      default: begin
      end
    endcase

    if (bad) begin
      r0.kind    = gzhs_pkg::KIND_STATUS;
      r0.status  = gzhs_pkg::STATUS_ERR;
      r0.is_last = 1'b1;
      n_res      = 2'd1;
    end else begin
      if (emit) begin
        r0.kind     = gzhs_pkg::KIND_PAYLOAD;
        r0.out_byte = dly_r[0];
        r0.is_last  = !eos;
        n_res       = 2'd1;
      end
      if (eos && phase_nxt != PH_DISCARD) begin
        r1.kind    = gzhs_pkg::KIND_STATUS;
        r1.status  = (phase_nxt == PH_PAYLOAD && fill_nxt == 4'(TRL)) ?
                     gzhs_pkg::STATUS_OK : gzhs_pkg::STATUS_ERR;
        r1.is_last = 1'b1;
        if (emit) begin
          n_res = 2'd2;
        end else begin
          r0    = r1;
          n_res = 2'd1;
        end
      end
    end

    // stream end returns the parse state to the start of a new member
    if (eos) begin
      phase_nxt = PH_FIXED;
      pos_nxt   = '0;
      flags_nxt = '0;
      xrem_nxt  = '0;
      xlow_nxt  = '0;
      fill_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIXED;
      pos_r   <= '0;
      flags_r <= '0;
      xrem_r  <= '0;
      xlow_r  <= '0;
      fill_r  <= '0;
      cnt_r   <= 2'd0;
    end else begin
      if (in_acc) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        flags_r <= flags_nxt;
        xrem_r  <= xrem_nxt;
        xlow_r  <= xlow_nxt;
        fill_r  <= fill_nxt;
        cnt_r   <= n_res;
        res0_r  <= r0;
        res1_r  <= r1;
        // oldest byte sits in entry 0, new byte enters at the top
        if (dly_shift) dly_r <= {b, dly_r[TRL-1:1]};
      end else if (out_acc) begin
        cnt_r  <= cnt_r - 2'd1;
        res0_r <= res1_r;
      end
    end
  end

  `GZHS_ASSERT(a_cnt_range, cnt_r != 2'd3, "output buffer count out of range")
  `GZHS_ASSERT(a_fill_range, fill_r <= 4'(TRL), "trailer line fill beyond depth")
  `GZHS_ASSERT(a_pair_order,
    (cnt_r != 2'd2) ||
    (res0_r.kind == gzhs_pkg::KIND_PAYLOAD && !res0_r.is_last &&
     res1_r.kind == gzhs_pkg::KIND_STATUS && res1_r.is_last),
    "buffered pair is not payload then status")
  `GZHS_ASSERT(a_status_clean,
    !(out_valid && out_data.kind == gzhs_pkg::KIND_STATUS) || out_data.out_byte == 8'd0,
    "status word carries a data byte")
  `GZHS_ASSERT_NEXT(a_eos_clear, in_acc && eos,
    phase_r == PH_FIXED && fill_r == 4'd0 && flags_r == 5'd0,
    "state not cleared after stream end")

endmodule
